FILE: rtl/suffix_and_lcp_array_builder_macros.svh
// Assertion macros for the suffix and LCP array builder.
// Taken in by the top level; needs clk and rst in the scope of each use.
`ifndef SUFFIX_AND_LCP_ARRAY_BUILDER_MACROS_SVH
`define SUFFIX_AND_LCP_ARRAY_BUILDER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, ignored during reset.
`define SAB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sab check failed");
// Next-cycle implication, ignored during reset.
`define SAB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sab check failed");
`else
`define SAB_ASSERT_IMP(lbl, ante, cons)
`define SAB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/sab_pkg.sv
// Shared types and constants of the suffix and LCP array builder.
// Used by sab_core and suffix_and_lcp_array_builder; no dependencies.
`default_nettype none
package sab_pkg;
  localparam int SAB_MAX_LEN     = 4096;
  localparam int SAB_SYMBOL_BITS = 8;

  // Fixed field widths of the stream beats.
  localparam int SYM_W    = 8;
  localparam int IDX_W    = 12;
  localparam int START_W  = 12;
  localparam int LCP_W    = 13;
  localparam int STAT_W   = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int RES_W    = START_W + LCP_W + STAT_W;

  // Beat kinds carried on s_tuser.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_NOBUILD = 2'd2,
    STAT_OVF     = 2'd3
  } status_t;

  // Commands from the stream front end to the core.
  typedef struct packed {
    logic load;
    logic start;
  } sab_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/sab_core.sv
// Memory core of the builder: the text, order, rank, count and LCP memories,
// and the sequencer that runs prefix doubling and the Kasai pass. Uses sab_pkg.
`default_nettype none
module sab_core import sab_pkg::*; #(
  parameter int MAX_LEN     = SAB_MAX_LEN,
  parameter int SYMBOL_BITS = SAB_SYMBOL_BITS,
  localparam int AW = $clog2(MAX_LEN),
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire sab_cmd_t               cmd,
  input  wire logic [LW-1:0]          n,
  input  wire logic [AW-1:0]          ld_addr,
  input  wire logic [SYMBOL_BITS-1:0] ld_sym,
  input  wire logic [AW-1:0]          rd_idx,
  output logic                        busy,
  output logic [AW-1:0]               rd_start,
  output logic [LW-1:0]               rd_lcp
);
  localparam int KW   = LW + 1;
  localparam int SMAX = 1 << SYMBOL_BITS;
  localparam int RMAX = (SMAX > MAX_LEN) ? SMAX : MAX_LEN;
  localparam int RW   = $clog2(RMAX + 1);
  localparam int NB   = (((SMAX + 1) > MAX_LEN) ? (SMAX + 1) : MAX_LEN) + 2;
  localparam int CAW  = $clog2(NB);
  localparam int BW   = $clog2(NB + 1);

  typedef enum logic [28:0] {
    S_IDLE  = 29'h0000001, S_INIT_RD = 29'h0000002, S_INIT_WR = 29'h0000004,
    S_CLR   = 29'h0000008, S_CNT_A = 29'h0000010, S_CNT_B = 29'h0000020,
    S_CNT_C = 29'h0000040, S_SUM_A = 29'h0000080, S_SUM_B = 29'h0000100,
    S_PL_A  = 29'h0000200, S_PL_B  = 29'h0000400, S_PL_C  = 29'h0000800,
    S_PL_D  = 29'h0001000, S_CP_A  = 29'h0002000, S_CP_B  = 29'h0004000,
    S_RK_A  = 29'h0008000, S_RK_B  = 29'h0010000, S_RK_C  = 29'h0020000,
    S_RK_D  = 29'h0040000, S_RC_A  = 29'h0080000, S_RC_B  = 29'h0100000,
    S_IV_A  = 29'h0200000, S_IV_B  = 29'h0400000, S_KS_A  = 29'h0800000,
    S_KS_B  = 29'h1000000, S_KS_C  = 29'h2000000, S_KS_D  = 29'h4000000,
    S_KS_E  = 29'h8000000, S_KS_F  = 29'h10000000
  } state_t;

  state_t state;

  // Memories, each with one write and one registered read port.
  logic [SYMBOL_BITS-1:0] txt_mem [MAX_LEN];
  logic [AW-1:0]          sa_mem  [MAX_LEN];
  logic [AW-1:0]          tmp_mem [MAX_LEN];
  logic [RW-1:0]          rk_mem  [MAX_LEN];
  logic [LW-1:0]          rks_mem [MAX_LEN];
  logic [LW-1:0]          cnt_mem [NB];
  logic [LW-1:0]          lcp_mem [MAX_LEN];

  logic [SYMBOL_BITS-1:0] txt_q, txt_wd;
  logic [AW-1:0]          sa_q, sa_wd, tmp_q, tmp_wd;
  logic [RW-1:0]          rk_q, rk_wd;
  logic [LW-1:0]          rks_q, rks_wd, cnt_q, cnt_wd, lcp_q, lcp_wd;
  logic [AW-1:0]          txt_ra, txt_wa, sa_ra, sa_wa, tmp_ra, tmp_wa;
  logic [AW-1:0]          rk_ra, rk_wa, rks_ra, rks_wa, lcp_wa;
  logic [CAW-1:0]         cnt_ra, cnt_wa;
  logic txt_we, sa_we, tmp_we, rk_we, rks_we, cnt_we, lcp_we;

  // Sequencer registers.
  logic [LW-1:0]  i, sum, r, h;
  logic [BW-1:0]  b;
  logic [KW-1:0]  k;
  logic           second;
  logic [RW-1:0]  key, cur_rank, prev_rank, prev_key;
  logic [AW-1:0]  s_reg, pos, j;
  logic [SYMBOL_BITS-1:0] ci;

  // Derived values.
  logic [KW-1:0] n_k, kk, p_i, p_sa, p_s, p_rk, ih, jh;
  logic [RW-1:0] key_i, key_s, key_rk;
  logic          last_i, last_b, differ;
  logic [LW-1:0] r_new, h_dec;

  assign n_k    = KW'(n);
  assign kk     = second ? '0 : k;
  assign p_i    = KW'(i) + kk;
  assign p_sa   = KW'(sa_q) + kk;
  assign p_s    = KW'(s_reg) + kk;
  assign p_rk   = KW'(s_reg) + k;
  assign ih     = KW'(i) + KW'(h);
  assign jh     = KW'(j) + KW'(h);
  assign key_i  = (p_i < n_k) ? rk_q : '0;
  assign key_s  = (p_s < n_k) ? rk_q : '0;
  assign key_rk = (p_rk < n_k) ? rk_q : '0;
  assign last_i = (LW'(i + LW'(1)) == n);
  assign last_b = (b == BW'(NB - 1));
  assign differ = (cur_rank != prev_rank) || (key_rk != prev_key);
  assign r_new  = (i == '0) ? LW'(1) : (differ ? r + LW'(1) : r);
  assign h_dec  = (h != '0) ? h - LW'(1) : '0;
  assign busy   = (state != S_IDLE);
  assign rd_start = sa_q;
  assign rd_lcp   = lcp_q;

  // Memory addresses and write data for the current step.
  always_comb begin
    txt_we = 1'b0; txt_wa = '0; txt_wd = '0; txt_ra = '0;
    sa_we = 1'b0; sa_wa = '0; sa_wd = '0; sa_ra = rd_idx;
    tmp_we = 1'b0; tmp_wa = '0; tmp_wd = '0; tmp_ra = '0;
    rk_we = 1'b0; rk_wa = '0; rk_wd = '0; rk_ra = '0;
    rks_we = 1'b0; rks_wa = '0; rks_wd = '0; rks_ra = '0;
    cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_ra = '0;
    lcp_we = 1'b0; lcp_wa = '0; lcp_wd = '0;
    case (state)
      S_IDLE: begin
        txt_we = cmd.load; txt_wa = ld_addr; txt_wd = ld_sym;
      end
      S_INIT_RD: txt_ra = AW'(i);
      S_INIT_WR: begin
        rk_we = 1'b1; rk_wa = AW'(i); rk_wd = RW'(txt_q) + RW'(1);
        sa_we = 1'b1; sa_wa = AW'(i); sa_wd = AW'(i);
      end
      S_CLR: begin
        cnt_we = 1'b1; cnt_wa = CAW'(b); cnt_wd = '0;
      end
      S_CNT_A: rk_ra = AW'(p_i);
      S_CNT_B: cnt_ra = CAW'(key_i);
      S_CNT_C: begin
        cnt_we = 1'b1; cnt_wa = CAW'(key); cnt_wd = cnt_q + LW'(1);
      end
      S_SUM_A: cnt_ra = CAW'(b);
      S_SUM_B: begin
        cnt_we = 1'b1; cnt_wa = CAW'(b); cnt_wd = sum;
      end
      S_PL_A: sa_ra = AW'(i);
      S_PL_B: rk_ra = AW'(p_sa);
      S_PL_C: cnt_ra = CAW'(key_s);
      S_PL_D: begin
        cnt_we = 1'b1; cnt_wa = CAW'(key); cnt_wd = cnt_q + LW'(1);
        tmp_we = 1'b1; tmp_wa = AW'(cnt_q); tmp_wd = s_reg;
      end
      S_CP_A: tmp_ra = AW'(i);
      S_CP_B: begin
        sa_we = 1'b1; sa_wa = AW'(i); sa_wd = tmp_q;
      end
      S_RK_A: sa_ra = AW'(i);
      S_RK_B: rk_ra = sa_q;
      S_RK_C: rk_ra = AW'(p_rk);
      S_RK_D: begin
        rks_we = 1'b1; rks_wa = s_reg; rks_wd = r_new;
      end
      S_RC_A: rks_ra = AW'(i);
      S_RC_B: begin
        rk_we = 1'b1; rk_wa = AW'(i); rk_wd = RW'(rks_q);
      end
      S_IV_A: sa_ra = AW'(i);
      S_IV_B: begin
        rks_we = 1'b1; rks_wa = sa_q; rks_wd = i;
      end
      S_KS_A: rks_ra = AW'(i);
      S_KS_B: begin
        sa_ra = AW'(rks_q - LW'(1));
        if (rks_q == '0) begin
          lcp_we = 1'b1; lcp_wa = '0; lcp_wd = '0;
        end
      end
      S_KS_D: begin
        txt_ra = AW'(ih);
        if (!(ih < n_k && jh < n_k)) begin
          lcp_we = 1'b1; lcp_wa = pos; lcp_wd = h;
        end
      end
      S_KS_E: txt_ra = AW'(jh);
      S_KS_F: begin
        if (txt_q != ci) begin
          lcp_we = 1'b1; lcp_wa = pos; lcp_wd = h;
        end
      end
      default: ;
    endcase
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (txt_we) txt_mem[txt_wa] <= txt_wd;
    if (sa_we)  sa_mem[sa_wa]   <= sa_wd;
    if (tmp_we) tmp_mem[tmp_wa] <= tmp_wd;
    if (rk_we)  rk_mem[rk_wa]   <= rk_wd;
    if (rks_we) rks_mem[rks_wa] <= rks_wd;
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (lcp_we) lcp_mem[lcp_wa] <= lcp_wd;
    txt_q <= txt_mem[txt_ra];
    sa_q  <= sa_mem[sa_ra];
    tmp_q <= tmp_mem[tmp_ra];
    rk_q  <= rk_mem[rk_ra];
    rks_q <= rks_mem[rks_ra];
    cnt_q <= cnt_mem[cnt_ra];
    lcp_q <= lcp_mem[rd_idx];
  end

  // Sequencer: one element of a pass per group of steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            i <= '0; k <= KW'(1); second <= 1'b0; state <= S_INIT_RD;
          end
        end
        S_INIT_RD: state <= S_INIT_WR;
        S_INIT_WR: begin
          i <= i + LW'(1);
          state <= S_INIT_RD;
          if (last_i) begin
            i <= '0; b <= '0;
            state <= (n_k > KW'(1)) ? S_CLR : S_IV_A;
          end
        end
        S_CLR: begin
          b <= b + BW'(1);
          if (last_b) begin
            i <= '0; state <= S_CNT_A;
          end
        end
        S_CNT_A: state <= S_CNT_B;
        S_CNT_B: begin
          key <= key_i; state <= S_CNT_C;
        end
        S_CNT_C: begin
          i <= i + LW'(1);
          state <= S_CNT_A;
          if (last_i) begin
            b <= '0; sum <= '0; state <= S_SUM_A;
          end
        end
        S_SUM_A: state <= S_SUM_B;
        S_SUM_B: begin
          sum <= sum + cnt_q;
          b <= b + BW'(1);
          state <= S_SUM_A;
          if (last_b) begin
            i <= '0; state <= S_PL_A;
          end
        end
        S_PL_A: state <= S_PL_B;
        S_PL_B: begin
          s_reg <= sa_q; state <= S_PL_C;
        end
        S_PL_C: begin
          key <= key_s; state <= S_PL_D;
        end
        S_PL_D: begin
          i <= i + LW'(1);
          state <= S_PL_A;
          if (last_i) begin
            i <= '0; state <= S_CP_A;
          end
        end
        S_CP_A: state <= S_CP_B;
        S_CP_B: begin
          i <= i + LW'(1);
          state <= S_CP_A;
          if (last_i) begin
            i <= '0; b <= '0;
            if (!second) begin
              second <= 1'b1; state <= S_CLR;
            end else begin
              state <= S_RK_A;
            end
          end
        end
        S_RK_A: state <= S_RK_B;
        S_RK_B: begin
          s_reg <= sa_q; state <= S_RK_C;
        end
        S_RK_C: begin
          cur_rank <= rk_q; state <= S_RK_D;
        end
        S_RK_D: begin
          r <= r_new;
          prev_rank <= cur_rank;
          prev_key <= key_rk;
          i <= i + LW'(1);
          state <= S_RK_A;
          if (last_i) begin
            i <= '0; state <= S_RC_A;
          end
        end
        S_RC_A: state <= S_RC_B;
        S_RC_B: begin
          i <= i + LW'(1);
          state <= S_RC_A;
          if (last_i) begin
            i <= '0; b <= '0;
            // Stop once all ranks differ or the next step covers the string.
            if (r == n || (k << 1) >= n_k) begin
              state <= S_IV_A;
            end else begin
              k <= k << 1; second <= 1'b0; state <= S_CLR;
            end
          end
        end
        S_IV_A: state <= S_IV_B;
        S_IV_B: begin
          i <= i + LW'(1);
          state <= S_IV_A;
          if (last_i) begin
            i <= '0; h <= '0; state <= S_KS_A;
          end
        end
        S_KS_A: state <= S_KS_B;
        S_KS_B: begin
          pos <= AW'(rks_q);
          if (rks_q == '0) begin
            h <= '0;
            i <= i + LW'(1);
            state <= last_i ? S_IDLE : S_KS_A;
          end else begin
            state <= S_KS_C;
          end
        end
        S_KS_C: begin
          j <= sa_q; state <= S_KS_D;
        end
        S_KS_D: begin
          if (ih < n_k && jh < n_k) begin
            state <= S_KS_E;
          end else begin
            h <= h_dec;
            i <= i + LW'(1);
            state <= last_i ? S_IDLE : S_KS_A;
          end
        end
        S_KS_E: begin
          ci <= txt_q; state <= S_KS_F;
        end
        S_KS_F: begin
          if (txt_q == ci) begin
            h <= h + LW'(1); state <= S_KS_D;
          end else begin
            h <= h_dec;
            i <= i + LW'(1);
            state <= last_i ? S_IDLE : S_KS_A;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/suffix_and_lcp_array_builder.sv
// Top level of the suffix and LCP array builder: stream front end, string
// bookkeeping and result queue. Uses sab_pkg, sab_core and the macros header.
`default_nettype none
`include "suffix_and_lcp_array_builder_macros.svh"
// Load beats (s_tuser 0) take one symbol each cycle while s_tready is high;
// the beat with s_tlast starts the build if the string fits and returns one
// result beat. Read beats (s_tuser 1) are taken one per cycle while s_tready
// is high; each result passes the result stage and a three-entry queue.
// While the build runs s_tready stays low. The build walks the memories one
// element at a time over single-port registered reads: a string of n symbols
// takes at most ceil(log2 n) doubling rounds, each sorting over NB count
// buckets, where NB is max(257, MAX_LEN) + 2, then the inverse and LCP passes.
module suffix_and_lcp_array_builder import sab_pkg::*; #(
  parameter int MAX_LEN     = SAB_MAX_LEN,
  parameter int SYMBOL_BITS = SAB_SYMBOL_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // symbol[7:0], index[19:8], zero
  input  wire logic                   s_tlast,   // last
  input  wire logic                   s_tuser,   // kind
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata    // suffix_start, common_prefix, status
);
  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = (LW > IDX_W) ? LW + 1 : IDX_W + 1;

  logic [LW-1:0] len;
  logic          built, ovf;
  logic          acc, is_load, fin, room;
  logic [LW-1:0] len_eff;
  logic [IDX_W-1:0] idx;
  sab_cmd_t      cmd;
  logic          busy;
  logic [AW-1:0] rd_start;
  logic [LW-1:0] rd_lcp;
  status_t       rd_stat;

  // Result waiting for memory data, then the queue.
  logic          pf_v, pf_mem;
  status_t       pf_stat;
  logic [RES_W-1:0] q [3];
  logic [1:0]    wp, rp, fcnt;
  logic          push, pop;
  logic [RES_W-1:0] res;

  assign idx     = s_tdata[SYM_W +: IDX_W];
  assign acc     = s_tvalid && s_tready;
  assign is_load = (s_tuser == KIND_LOAD);
  assign fin     = built || ovf;
  assign len_eff = fin ? '0 : len;
  assign room    = len_eff < LW'(MAX_LEN);
  assign s_tready = !busy && ((3'(fcnt) + 3'(pf_v)) <= 3'd2);

  assign cmd.load  = acc && is_load && room;
  assign cmd.start = acc && is_load && room && s_tlast;

  // Status of a read beat.
  always_comb begin
    if (ovf)                       rd_stat = STAT_OVF;
    else if (!built)               rd_stat = STAT_NOBUILD;
    else if (CW'(idx) >= CW'(len)) rd_stat = STAT_RANGE;
    else                           rd_stat = STAT_OK;
  end

  sab_core #(.MAX_LEN(MAX_LEN), .SYMBOL_BITS(SYMBOL_BITS)) u_core (
    .clk(clk), .rst(rst), .cmd(cmd), .n(len),
    .ld_addr(AW'(len_eff)), .ld_sym(s_tdata[SYMBOL_BITS-1:0]),
    .rd_idx(AW'(idx)), .busy(busy), .rd_start(rd_start), .rd_lcp(rd_lcp)
  );

  // String bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0; built <= 1'b0; ovf <= 1'b0;
    end else if (acc && is_load) begin
      len   <= room ? len_eff + LW'(1) : len_eff;
      ovf   <= !room;
      built <= s_tlast && room;
    end
  end

  // Result stage: load beats with last and every read beat answer.
  always_ff @(posedge clk) begin
    if (rst) begin
      pf_v <= 1'b0;
    end else begin
      pf_v <= acc && (!is_load || s_tlast);
    end
    pf_stat <= is_load ? (room ? STAT_OK : STAT_OVF) : rd_stat;
    pf_mem  <= !is_load && (rd_stat == STAT_OK);
  end

  assign res = pf_mem ? {STAT_OK, LCP_W'(rd_lcp), START_W'(rd_start)}
                      : {pf_stat, {(LCP_W + START_W){1'b0}}};
  assign push = pf_v;
  assign pop  = m_tvalid && m_tready;

  // Three-entry result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; fcnt <= '0;
    end else begin
      if (push) wp <= (wp == 2'd2) ? 2'd0 : wp + 2'd1;
      if (pop)  rp <= (rp == 2'd2) ? 2'd0 : rp + 2'd1;
      fcnt <= fcnt + 2'(push) - 2'(pop);
    end
    if (push) q[wp] <= res;
  end

  assign m_tvalid = (fcnt != 2'd0);
  assign m_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, q[rp]};

  `SAB_ASSERT_IMP(a_start_idle, cmd.start, !busy)
  `SAB_ASSERT_NXT(a_start_busy, cmd.start, busy)
  `SAB_ASSERT_IMP(a_queue_room, push && (fcnt == 2'd3), pop)
  `SAB_ASSERT_IMP(a_len_bound, 1'b1, len <= LW'(MAX_LEN))
endmodule
`default_nettype wire

FILE: bench/tb.sv
// Testbench for suffix_and_lcp_array_builder: loads byte strings, reads back
// the suffix and LCP arrays and checks every result beat against a predictor.
// Depends on sab_pkg and the RTL of the block only.
module tb;
  import sab_pkg::*;

  localparam int NB = 4098;

  typedef struct {
    logic       kind;
    logic [7:0] sym;
    logic       last;
    logic [11:0] idx;
    bit         drain;
  } beat_t;

  typedef struct {
    logic [11:0] start;
    logic [12:0] lcp;
    status_t     stat;
  } entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  beat_t  pending[$];
  entry_t expected[$];
  int     errors = 0;
  logic   in_fire = 1'b0;
  logic   out_fire = 1'b0;
  int     send_gap = 0;
  int     recv_stall = 0;
  bit     no_idle = 1'b0;

  // Predictor state.
  int text_mem[4096];
  int order_mem[4096];
  int order_tmp[4096];
  int rank_mem[4096];
  int rank_tmp[4096];
  int bucket[NB];
  int lcp_mem[4096];
  int str_len = 0;
  bit built = 1'b0;
  bit overflowed = 1'b0;

  suffix_and_lcp_array_builder DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  // Second-half key of a suffix; past-end positions rank below all ranks.
  function automatic int half_key(int pos, int k, int n);
    return (pos + k < n) ? rank_mem[pos + k] : 0;
  endfunction

  // One stable counting sort of the order by the key at offset k.
  function automatic void radix_pass(int k, int n);
    int sum;
    int t;
    int key;
    sum = 0;
    for (int i = 0; i < NB; i++) bucket[i] = 0;
    for (int i = 0; i < n; i++) bucket[half_key(i, k, n)]++;
    for (int i = 0; i < NB; i++) begin
      t = bucket[i];
      bucket[i] = sum;
      sum += t;
    end
    for (int i = 0; i < n; i++) begin
      key = half_key(order_mem[i], k, n);
      order_tmp[bucket[key]] = order_mem[i];
      bucket[key]++;
    end
    for (int i = 0; i < n; i++) order_mem[i] = order_tmp[i];
  endfunction

  // Prefix doubling sort followed by the Kasai LCP pass.
  function automatic void build_arrays(int n);
    int r;
    int a;
    int b;
    int h;
    int pos;
    int j;
    for (int i = 0; i < n; i++) begin
      rank_mem[i] = text_mem[i] + 1;
      order_mem[i] = i;
    end
    for (int k = 1; k < n; k = k << 1) begin
      radix_pass(k, n);
      radix_pass(0, n);
      r = 1;
      rank_tmp[order_mem[0]] = 1;
      for (int i = 1; i < n; i++) begin
        a = order_mem[i];
        b = order_mem[i - 1];
        if (!(rank_mem[a] == rank_mem[b] && half_key(a, k, n) == half_key(b, k, n))) r++;
        rank_tmp[a] = r;
      end
      for (int i = 0; i < n; i++) rank_mem[i] = rank_tmp[i];
      if (r == n) break;
    end
    for (int i = 0; i < n; i++) rank_tmp[order_mem[i]] = i;
    h = 0;
    for (int i = 0; i < n; i++) begin
      pos = rank_tmp[i];
      if (pos == 0) begin
        lcp_mem[0] = 0;
        h = 0;
      end else begin
        j = order_mem[pos - 1];
        while (i + h < n && j + h < n && text_mem[i + h] == text_mem[j + h]) h++;
        lcp_mem[pos] = h;
        if (h > 0) h--;
      end
    end
  endfunction

  // Apply one accepted beat to the predictor and queue any result.
  function automatic void predict_beat(logic kind, logic [7:0] sym, logic last,
                                       logic [11:0] idx);
    entry_t e;
    e.start = '0;
    e.lcp = '0;
    e.stat = STAT_OK;
    if (kind == KIND_LOAD) begin
      if (built || overflowed) begin
        str_len = 0;
        built = 1'b0;
        overflowed = 1'b0;
      end
      if (str_len < SAB_MAX_LEN) begin
        text_mem[str_len] = sym;
        str_len++;
      end else begin
        overflowed = 1'b1;
      end
      if (!last) return;
      if (overflowed) e.stat = STAT_OVF;
      else begin
        build_arrays(str_len);
        built = 1'b1;
      end
    end else if (overflowed) e.stat = STAT_OVF;
    else if (!built) e.stat = STAT_NOBUILD;
    else if (idx >= str_len) e.stat = STAT_RANGE;
    else begin
      e.start = 12'(order_mem[idx]);
      e.lcp = 13'(lcp_mem[idx]);
    end
    expected.push_back(e);
  endfunction

  // Input driver: one beat per handshake, random gaps, optional drain points.
  always @(negedge clk) begin
    logic nv;
    beat_t b;
    nv = s_tvalid && !in_fire;
    if (!rst && !nv) begin
      if (send_gap > 0) send_gap--;
      else if (pending.size() > 0) begin
        if (pending[0].drain) begin
          if (expected.size() == 0 && !in_fire) void'(pending.pop_front());
        end else begin
          b = pending.pop_front();
          s_tuser <= b.kind;
          s_tlast <= b.last;
          s_tdata <= {4'b0, b.idx, b.sym};
          nv = 1'b1;
          if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
          send_gap = no_idle ? 0 : $urandom_range(0, 16);
        end
      end
    end
    s_tvalid <= nv;
  end

  // Output stall pattern, drawn once per result beat.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else begin
      if (out_fire) recv_stall = no_idle ? 0 : $urandom_range(0, 16);
      else if (recv_stall > 0) recv_stall--;
      m_tready <= (recv_stall == 0);
    end
  end

  // Monitor: check result beats and feed accepted input beats to the predictor.
  always @(posedge clk) begin
    entry_t e;
    in_fire <= !rst && s_tvalid && s_tready;
    out_fire <= !rst && m_tvalid && m_tready;
    if (!rst && m_tvalid && m_tready) begin
      if (expected.size() == 0) begin
        $error("unexpected result beat %h", m_tdata);
        errors++;
      end else begin
        e = expected.pop_front();
        if (m_tdata[11:0] !== e.start) begin
          $error("suffix_start: expected %0d, got %0d", e.start, m_tdata[11:0]);
          errors++;
        end
        if (m_tdata[24:12] !== e.lcp) begin
          $error("common_prefix: expected %0d, got %0d", e.lcp, m_tdata[24:12]);
          errors++;
        end
        if (m_tdata[26:25] !== e.stat) begin
          $error("status: expected %0d, got %0d", e.stat, m_tdata[26:25]);
          errors++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready)
      predict_beat(s_tuser, s_tdata[7:0], s_tlast, s_tdata[19:8]);
  end

  function automatic void add_load(logic [7:0] sym, logic last);
    beat_t b;
    b = '{KIND_LOAD, sym, last, 12'($urandom), 1'b0};
    pending.push_back(b);
  endfunction

  function automatic void add_read(logic [11:0] idx);
    beat_t b;
    b = '{KIND_READ, 8'($urandom), 1'($urandom), idx, 1'b0};
    pending.push_back(b);
  endfunction

  function automatic void add_drain();
    beat_t b;
    b = '{KIND_LOAD, 8'h0, 1'b0, 12'h0, 1'b1};
    pending.push_back(b);
  endfunction

  // Random string of length n over a small or full alphabet, with reads mixed in and after.
  function automatic int add_string(int n, int reads);
    int alpha;
    int count;
    alpha = $urandom_range(0, 2);
    count = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        add_read(12'($urandom));
        count++;
      end
      case (alpha)
        0: add_load(8'($urandom_range(0, 1)) ^ 8'hA5, i == n - 1);
        1: add_load(8'($urandom_range(0, 3)), i == n - 1);
        default: add_load(8'($urandom), i == n - 1);
      endcase
      count++;
    end
    for (int i = 0; i < reads; i++) begin
      if ($urandom_range(0, 9) == 0) add_read(12'($urandom_range(n, 4095)));
      else add_read(12'($urandom_range(0, n - 1)));
      count++;
    end
    return count;
  endfunction

  // Stimulus and end of run.
  initial begin
    int total;
    // Reads before any build, at both index extremes.
    add_read(12'd0);
    add_read(12'd4095);
    // Extreme symbols, with a read while loading.
    add_load(8'd0, 1'b0);
    add_load(8'd255, 1'b0);
    add_read(12'd1);
    add_load(8'd0, 1'b0);
    add_load(8'd255, 1'b0);
    add_load(8'd0, 1'b1);
    for (int i = 0; i < 6; i++) add_read(12'(i));
    add_read(12'd4095);
    add_drain();
    // Single symbol string.
    add_load(8'd7, 1'b1);
    add_read(12'd0);
    add_read(12'd1);
    // Repeated symbol forces every doubling round.
    for (int i = 0; i < 12; i++) add_load(8'h61, i == 11);
    for (int i = 0; i < 12; i++) add_read(12'(i));
    add_drain();
    // Random part.
    total = add_string(100, 40);
    while (total < 810) begin
      total += add_string($urandom_range(2, 24), $urandom_range(40, 90));
      if ($urandom_range(0, 3) == 0) add_drain();
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0 && !s_tvalid);
    wait (expected.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Run limit.
  initial begin
    #80000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
